[rtl/msp_pkg.sv]
// msp_pkg: shared widths, register map codes and unit status type
// for the motor speed pid regulator core; no dependencies
package msp_pkg;

  // field widths
  localparam int unsigned SCALE_W  = 20;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned MAG_W    = 15;
  localparam int unsigned ERR_W    = 17;
  localparam int unsigned DIFF_W   = 18;
  localparam int unsigned DUTY_OUT_W = 7;

  // constants
  localparam logic [MAG_W-1:0]   SPEED_SAT   = 15'h7fff;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd256082;
  localparam int unsigned        MAC_TERMS   = 3;

  // register map, word index on the config port
  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_GAIN_P = 3'd1,
    REG_GAIN_I = 3'd2,
    REG_GAIN_D = 3'd3,
    REG_SCALE  = 3'd4
  } msp_reg_e;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } msp_sts_t;

endpackage

[rtl/msp_div.sv]
// msp_div: restoring bit-serial divider, one quotient bit per cycle
// depends on msp_pkg
module msp_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [msp_pkg::SCALE_W-1:0]    dividend_i,
  input  logic [msp_pkg::PERIOD_W-1:0]   divisor_i,
  output logic [msp_pkg::SCALE_W-1:0]    quotient_o,
  output msp_pkg::msp_sts_t              sts_o
);
  import msp_pkg::*;

  localparam int unsigned CNT_W = $clog2(SCALE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCALE_W - 1);

  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [SCALE_W-1:0]  quo_q, quo_d;
  logic [PERIOD_W-1:0] dvs_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q, done_q;
  logic [PERIOD_W:0]   rem_sh, rem_sub;
  logic                ge;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_q, quo_q[SCALE_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    rem_d   = ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
    quo_d   = {quo_q[SCALE_W-2:0], ge};
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

[rtl/msp_mac.sv]
// msp_mac: serial shift-add multiply-accumulate of three gain terms,
// one gain bit per cycle; depends on msp_pkg
module msp_mac #(
  parameter int unsigned OP_W = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [OP_W-1:0]            op_i   [msp_pkg::MAC_TERMS],
  input  logic [msp_pkg::GAIN_W-1:0]        gain_i [msp_pkg::MAC_TERMS],
  output logic signed [OP_W+17:0]           total_o,
  output msp_pkg::msp_sts_t                 sts_o
);
  import msp_pkg::*;

  localparam int unsigned TW    = OP_W + 18;
  localparam int unsigned BIT_W = $clog2(GAIN_W);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(GAIN_W - 1);
  localparam logic [1:0] PH_LAST = 2'(MAC_TERMS - 1);

  logic signed [TW-1:0] total_q, mcand_q;
  logic [GAIN_W-1:0]    mplr_q;
  logic [BIT_W-1:0]     bit_q;
  logic [1:0]           phase_q;
  logic                 busy_q, done_q;
  logic signed [OP_W-1:0] next_op;
  logic [GAIN_W-1:0]      next_gain;

  // operand for the following term
  always_comb begin
    case (phase_q)
      2'd0:    begin next_op = op_i[1]; next_gain = gain_i[1]; end
      default: begin next_op = op_i[2]; next_gain = gain_i[2]; end
    endcase
  end

  // sequencing over terms and gain bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      bit_q   <= '0;
      phase_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        bit_q   <= '0;
        phase_q <= '0;
      end else if (busy_q) begin
        if (bit_q == BIT_LAST) begin
          bit_q <= '0;
          if (phase_q == PH_LAST) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            phase_q <= phase_q + 1'b1;
          end
        end else begin
          bit_q <= bit_q + 1'b1;
        end
      end
    end
  end

  // shift-add datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      total_q <= '0;
      mcand_q <= TW'(op_i[0]);
      mplr_q  <= gain_i[0];
    end else if (busy_q) begin
      total_q <= total_q + (mplr_q[0] ? mcand_q : '0);
      if (bit_q == BIT_LAST) begin
        mcand_q <= TW'(next_op);
        mplr_q  <= next_gain;
      end else begin
        mcand_q <= mcand_q <<< 1;
        mplr_q  <= mplr_q >> 1;
      end
    end
  end

  assign total_o    = total_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

[rtl/motor_speed_pid_regulator_core.sv]
// motor_speed_pid_regulator_core: speed from pulse period and positional pid
// sequence per word: serial divide, error, serial mac, commit; a stop command or
// zero-target word goes straight to commit; a new word is taken only in idle, after
// the last result is committed, so throughput is set by the serial divider and the serial mac
// reset: asynchronous active-low, clears loop state and outputs, registers to defaults
// depends on msp_pkg, msp_div, msp_mac
module motor_speed_pid_regulator_core #(
  parameter int unsigned ACC_WIDTH = 32,
  parameter int unsigned DUTY_MAX  = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] pulse_period
  input  logic        s_axis_tuser,   // [0] command
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] pwm_duty, [7] bridge_in1, [8] bridge_in2, [9] running_flag,
  // [10] forward_flag, [26:11] measured_speed, [31:27] zero
  output logic [31:0] m_axis_tdata,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import msp_pkg::*;

  localparam int unsigned TW = ACC_WIDTH + 18;
  localparam int unsigned DW = $clog2(DUTY_MAX + 1);
  localparam logic signed [TW-1:0] DUTY_LIM = TW'(DUTY_MAX * 256);
  localparam logic [DW-1:0] DUTY_TOP = DW'(DUTY_MAX);
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_ERR  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic signed [SPEED_W-1:0] target_q;
  logic [GAIN_W-1:0]         gain_p_q, gain_i_q, gain_d_q;
  logic [SCALE_W-1:0]        scale_q;

  // loop state and outputs
  logic signed [ERR_W-1:0]     last_err_q;
  logic signed [ACC_WIDTH-1:0] acc_q;
  logic signed [SPEED_W-1:0]   speed_q;
  logic [DUTY_OUT_W-1:0]       duty_q;
  logic [3:0]                  flags_q;   // in1, in2, running, forward
  logic                        m_valid_q;

  // per-item control and operands
  logic                        stop_q, skip_q, per_zero_q;
  logic [MAG_W-1:0]            mag_q;
  logic signed [ERR_W-1:0]     err_q;
  logic signed [DIFF_W-1:0]    diff_q;

  logic                        accept, cfg_wr, commit, tgt_neg, tgt_zero;
  logic [SCALE_W-1:0]          quotient;
  msp_sts_t                    div_sts, mac_sts;
  logic [MAG_W-1:0]            mag_d;
  logic signed [ERR_W-1:0]     tgt_ext, tmag, err_d;
  logic signed [DIFF_W-1:0]    diff_d;
  logic signed [ACC_WIDTH:0]   acc_sum;
  logic signed [ACC_WIDTH-1:0] acc_d;
  logic signed [ACC_WIDTH-1:0] mac_op [MAC_TERMS];
  logic [GAIN_W-1:0]           mac_gain [MAC_TERMS];
  logic signed [TW-1:0]        total;
  logic [DW-1:0]               duty_full;
  logic [DW+DUTY_OUT_W-1:0]    duty_ext;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign tgt_neg  = target_q[SPEED_W-1];
  assign tgt_zero = (target_q == '0);
  assign commit   = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      scale_q  <= SCALE_RESET;
    end else if (cfg_wr) begin
      case (msp_reg_e'(paddr[4:2]))
        REG_TARGET: target_q <= pwdata[SPEED_W-1:0];
        REG_GAIN_P: gain_p_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_I: gain_i_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_D: gain_d_q <= pwdata[GAIN_W-1:0];
        REG_SCALE:  scale_q  <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // config readback
  always_comb begin
    case (msp_reg_e'(paddr[4:2]))
      REG_TARGET: prdata = {{(32-SPEED_W){1'b0}}, target_q};
      REG_GAIN_P: prdata = {{(32-GAIN_W){1'b0}}, gain_p_q};
      REG_GAIN_I: prdata = {{(32-GAIN_W){1'b0}}, gain_i_q};
      REG_GAIN_D: prdata = {{(32-GAIN_W){1'b0}}, gain_d_q};
      REG_SCALE:  prdata = {{(32-SCALE_W){1'b0}}, scale_q};
      default:    prdata = '0;
    endcase
  end

  // serial speed divider
  msp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && !s_axis_tuser && !tgt_zero),
    .dividend_i (scale_q),
    .divisor_i  (s_axis_tdata[PERIOD_W-1:0]),
    .quotient_o (quotient),
    .sts_o      (div_sts)
  );

  // speed magnitude, error, difference and saturated accumulator
  always_comb begin
    if (per_zero_q || (quotient > SCALE_W'(SPEED_SAT))) begin
      mag_d = SPEED_SAT;
    end else begin
      mag_d = quotient[MAG_W-1:0];
    end
    tgt_ext = ERR_W'(target_q);
    tmag    = tgt_neg ? -tgt_ext : tgt_ext;
    err_d   = tmag - $signed({2'b00, mag_d});
    diff_d  = DIFF_W'(err_d) - DIFF_W'(last_err_q);
    acc_sum = (ACC_WIDTH+1)'(acc_q) + (ACC_WIDTH+1)'(err_d);
    if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
      acc_d = acc_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_d = acc_sum[ACC_WIDTH-1:0];
    end
  end

  // mac operands: p term starts from the fresh error, later terms from registers
  assign mac_op[0]   = ACC_WIDTH'(err_d);
  assign mac_op[1]   = ACC_WIDTH'(diff_q);
  assign mac_op[2]   = acc_q;
  assign mac_gain[0] = gain_p_q;
  assign mac_gain[1] = gain_d_q;
  assign mac_gain[2] = gain_i_q;

  msp_mac #(
    .OP_W (ACC_WIDTH)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_ERR),
    .op_i    (mac_op),
    .gain_i  (mac_gain),
    .total_o (total),
    .sts_o   (mac_sts)
  );

  // duty clamp
  always_comb begin
    if (total[TW-1] || (total == '0)) begin
      duty_full = '0;
    end else if (total >= DUTY_LIM) begin
      duty_full = DUTY_TOP;
    end else begin
      duty_full = total[8+DW-1:8];
    end
    duty_ext = {{DUTY_OUT_W{1'b0}}, duty_full};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (s_axis_tuser || tgt_zero) ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        if (div_sts.done) state_d = S_ERR;
      end
      S_ERR: state_d = S_MUL;
      S_MUL: begin
        if (mac_sts.done) state_d = S_FIN;
      end
      S_FIN: begin
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // control and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      stop_q     <= 1'b0;
      skip_q     <= 1'b0;
      per_zero_q <= 1'b0;
      m_valid_q  <= 1'b0;
      last_err_q <= '0;
      acc_q      <= '0;
      speed_q    <= '0;
      duty_q     <= '0;
      flags_q    <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        stop_q     <= s_axis_tuser;
        skip_q     <= tgt_zero;
        per_zero_q <= (s_axis_tdata[PERIOD_W-1:0] == '0);
      end
      if (state_q == S_ERR) begin
        acc_q <= acc_d;
      end
      if (commit) begin
        m_valid_q <= 1'b1;
        if (stop_q) begin
          last_err_q <= '0;
          acc_q      <= '0;
          speed_q    <= '0;
          duty_q     <= '0;
          flags_q    <= '0;
        end else if (!skip_q) begin
          last_err_q <= err_q;
          speed_q    <= tgt_neg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
          duty_q     <= duty_ext[DUTY_OUT_W-1:0];
          flags_q    <= tgt_neg ? 4'b0101 : 4'b1110;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // per-item operands
  always_ff @(posedge clk_i) begin
    if (state_q == S_ERR) begin
      mag_q  <= mag_d;
      err_q  <= err_d;
      diff_q <= diff_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b00000, speed_q, flags_q[3], flags_q[2], flags_q[1],
                          flags_q[0], duty_q};

`ifndef ASSERT_OFF
  // a stop command leaves an all-zero result
  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && stop_q) |=> (m_axis_tdata == '0))
    else $error("stop did not clear result");

  // the running flag only drops through reset or stop, with everything zero
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flags_q[2] |-> ((duty_q == '0) && (speed_q == '0) && (flags_q == '0)))
    else $error("stopped motor with nonzero outputs");

  // mac finishes only while the sequencer waits for it
  a_mac_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_sts.done |-> (state_q == S_MUL))
    else $error("mac done outside multiply phase");

  // divider finishes only while the sequencer waits for it
  a_div_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == S_DIV))
    else $error("divider done outside divide phase");
`endif

endmodule

[dv/tb_top.sv]
// tb_top: self-checking testbench for motor_speed_pid_regulator_core, a directed
// table then random control phases, checked against known words or an in-bench speed loop model
// depends on msp_pkg and the core rtl only
`timescale 1ns / 100ps

module tb_top;
  import msp_pkg::*;

  localparam int unsigned ACC_BITS   = 32;
  localparam int unsigned DUTY_LIMIT = 100;
  localparam int          ITEM_TOTAL = 1100;
  localparam int          QUIET_TAIL = 150;
  localparam int          LONG_HOLD  = 400;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          TAIL_WAIT  = 80;
  localparam longint      ACC_MAX    = (64'sd1 <<< (ACC_BITS - 1)) - 1;
  localparam longint      ACC_MIN    = -ACC_MAX - 1;
  localparam longint      ITERM_MAX  = 64'sd1 <<< 40;

  // one result word as it sits in m_axis_tdata[26:0]
  typedef struct packed {
    logic [15:0] speed;
    logic        fwd;
    logic        run;
    logic        in2;
    logic        in1;
    logic [6:0]  duty;
  } drive_word_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_KNOWN
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    msp_reg_e    regsel;
    logic [31:0] value;
    logic        cmd;
    logic [15:0] period;
    drive_word_t known;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] pulse_period
  logic        s_axis_tuser = 1'b0; // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [6:0] duty, [7] in1, [8] in2, [9] run, [10] fwd, [26:11] speed
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // register shadow
  logic signed [15:0] cfg_target;
  logic [15:0]        cfg_kp, cfg_ki, cfg_kd;
  logic [19:0]        cfg_scale;

  // loop state shadow
  longint      loop_last_err, loop_acc;
  logic [15:0] loop_speed;
  logic [6:0]  loop_duty;
  logic [3:0]  loop_pins; // in1, in2, run, fwd from bit 0 up

  drive_word_t expected_drive_q[$];
  plan_row_t   stim_plan[$];
  int          items_sent = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  motor_speed_pid_regulator_core #(
    .ACC_WIDTH(ACC_BITS),
    .DUTY_MAX (DUTY_LIMIT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk_i = ~clk_i;

  // speed estimate and positional pid for one accepted word
  function automatic drive_word_t advance_speed_loop(input logic cmd, input logic [15:0] period);
    longint      mag, tmag, err, diff, pd, iterm, total;
    drive_word_t w;
    if (cmd) begin
      loop_last_err = 0;
      loop_acc      = 0;
      loop_speed    = '0;
      loop_duty     = '0;
      loop_pins     = '0;
    end else if (cfg_target != 0) begin
      if (period == 0) begin
        mag = longint'(SPEED_SAT);
      end else begin
        mag = longint'(cfg_scale) / longint'(period);
        if (mag > longint'(SPEED_SAT)) mag = longint'(SPEED_SAT);
      end
      tmag       = (cfg_target < 0) ? -longint'(cfg_target) : longint'(cfg_target);
      loop_speed = (cfg_target < 0) ? 16'(-mag) : 16'(mag);
      err        = tmag - mag;
      diff       = err - loop_last_err;
      loop_acc   = loop_acc + err;
      if (loop_acc > ACC_MAX) loop_acc = ACC_MAX;
      if (loop_acc < ACC_MIN) loop_acc = ACC_MIN;
      pd    = longint'(cfg_kp) * err + longint'(cfg_kd) * diff;
      iterm = longint'(cfg_ki) * loop_acc;
      if (iterm > ITERM_MAX) iterm = ITERM_MAX;
      if (iterm < -ITERM_MAX) iterm = -ITERM_MAX;
      total = pd + iterm;
      if (total <= 0) loop_duty = '0;
      else if (total >= longint'(DUTY_LIMIT) * 256) loop_duty = 7'(DUTY_LIMIT);
      else loop_duty = 7'(total >>> 8);
      loop_last_err = err;
      loop_pins     = (cfg_target > 0) ? 4'b1110 : 4'b0101;
    end
    w.speed = loop_speed;
    w.fwd   = loop_pins[3];
    w.run   = loop_pins[2];
    w.in2   = loop_pins[1];
    w.in1   = loop_pins[0];
    w.duty  = loop_duty;
    return w;
  endfunction

  function automatic void check_field(input string label, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", label, want, got);
      mismatches++;
    end
  endfunction

  function automatic void add_row(input row_kind_e kind, input msp_reg_e regsel,
                                  input logic [31:0] value, input logic cmd,
                                  input logic [15:0] period, input drive_word_t known);
    plan_row_t r;
    r.kind   = kind;
    r.regsel = regsel;
    r.value  = value;
    r.cmd    = cmd;
    r.period = period;
    r.known  = known;
    stim_plan.push_back(r);
  endfunction

  function automatic logic [15:0] pick_target();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h8001;
      3: return 16'h0000;
      4: return 16'($urandom_range(1, 50));
      5: return 16'(-$urandom_range(1, 50));
      6, 7: return 16'($urandom_range(200, 3000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3: return 16'($urandom_range(0, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return 20'd0;
      1: return 20'd1;
      2: return 20'hfffff;
      3, 4: return SCALE_RESET;
      default: return 20'($urandom);
    endcase
  endfunction

  // periods mostly near the one that matches the target speed
  function automatic logic [15:0] pick_period();
    longint mag, nominal, spread;
    mag = (cfg_target < 0) ? -longint'(cfg_target) : longint'(cfg_target);
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h0001;
      3, 4: return 16'($urandom);
      default: begin
        if (mag == 0 || cfg_scale == 0) return 16'($urandom);
        nominal = longint'(cfg_scale) / mag;
        spread  = nominal / 8 + 2;
        nominal = nominal + longint'($urandom_range(0, 32'(2 * spread))) - spread;
        if (nominal < 0) nominal = 0;
        if (nominal > 65535) nominal = 65535;
        return 16'(nominal);
      end
    endcase
  endfunction

  // config write, setup then access; caller closes the bus
  task automatic set_register(input msp_reg_e regsel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (regsel)
      REG_TARGET: cfg_target = value[15:0];
      REG_GAIN_P: cfg_kp = value[15:0];
      REG_GAIN_I: cfg_ki = value[15:0];
      REG_GAIN_D: cfg_kd = value[15:0];
      REG_SCALE:  cfg_scale = value[19:0];
      default: ;
    endcase
  endtask

  task automatic close_bus();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // offer one word, record the expected drive word once it is taken
  task automatic send_word(input logic cmd, input logic [15:0] period,
                           input bit use_known, input drive_word_t known);
    drive_word_t w;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= period;
    do @(posedge clk_i); while (!s_axis_tready);
    w = advance_speed_loop(cmd, period);
    expected_drive_q.push_back(use_known ? known : w);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_drive_q.size() != 0);
  endtask

  // result sink with random stalls and one long hold-off
  initial begin : result_sink
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        n = 0;
        while (n < LONG_HOLD) begin
          @(posedge clk_i);
          n++;
        end
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    drive_word_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[26:0];
      if (expected_drive_q.size() == 0) begin
        $error("unexpected result word 0x%08h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_drive_q.pop_front();
        check_field("pwm_duty", int'(want.duty), int'(got.duty));
        check_field("bridge_in1", int'(want.in1), int'(got.in1));
        check_field("bridge_in2", int'(want.in2), int'(got.in2));
        check_field("running_flag", int'(want.run), int'(got.run));
        check_field("forward_flag", int'(want.fwd), int'(got.fwd));
        check_field("measured_speed", int'($signed(want.speed)), int'($signed(got.speed)));
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    bit     prev_cfg;
    int     phase, len;
    logic   cmd;

    // reset values of the shadows
    cfg_target    = '0;
    cfg_kp        = '0;
    cfg_ki        = '0;
    cfg_kd        = '0;
    cfg_scale     = SCALE_RESET;
    loop_last_err = 0;
    loop_acc      = 0;
    loop_speed    = '0;
    loop_duty     = '0;
    loop_pins     = '0;

    // directed table: reset state, stop, exact speeds, extremes, hold on zero target
    add_row(ROW_KNOWN, REG_TARGET, '0, 1'b0, 16'h1234, '0);
    add_row(ROW_KNOWN, REG_TARGET, '0, 1'b1, 16'hffff, '0);
    add_row(ROW_CFG,   REG_TARGET, 32'hdead_03e8, 1'b0, '0, '0);
    add_row(ROW_CFG,   REG_GAIN_P, 32'd256, 1'b0, '0, '0);
    add_row(ROW_KNOWN, REG_TARGET, '0, 1'b0, 16'd0, {16'd32767, 4'b1110, 7'd0});
    add_row(ROW_KNOWN, REG_TARGET, '0, 1'b0, 16'hffff, {16'd3, 4'b1110, 7'd100});
    add_row(ROW_KNOWN, REG_TARGET, '0, 1'b0, 16'd256, {16'd1000, 4'b1110, 7'd0});
    add_row(ROW_KNOWN, REG_TARGET, '0, 1'b0, 16'd262, {16'd977, 4'b1110, 7'd23});
    add_row(ROW_KNOWN, REG_TARGET, '0, 1'b1, 16'h5a5a, '0);
    add_row(ROW_CFG,   REG_GAIN_P, 32'hffff_ffff, 1'b0, '0, '0);
    add_row(ROW_CFG,   REG_GAIN_I, 32'h0000_ffff, 1'b0, '0, '0);
    add_row(ROW_CFG,   REG_GAIN_D, 32'h0000_ffff, 1'b0, '0, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'd1, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'd300, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'hffff, '0);
    // most negative target
    add_row(ROW_CFG,   REG_TARGET, 32'h0000_8000, 1'b0, '0, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'd7, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'd0, '0);
    add_row(ROW_CFG,   REG_TARGET, 32'hffff_7fff, 1'b0, '0, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'hffff, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'hffff, '0);
    // zero scale gives zero speed
    add_row(ROW_CFG,   REG_SCALE,  32'hfff0_0000, 1'b0, '0, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'd100, '0);
    add_row(ROW_CFG,   REG_SCALE,  32'hffff_ffff, 1'b0, '0, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'd1, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'hffff, '0);
    // zero target holds the last word
    add_row(ROW_CFG,   REG_TARGET, 32'hffff_0000, 1'b0, '0, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'd5, '0);
    add_row(ROW_KNOWN, REG_TARGET, '0, 1'b1, 16'd0, '0);
    add_row(ROW_CFG,   REG_TARGET, 32'h0000_ffff, 1'b0, '0, '0);
    add_row(ROW_CFG,   REG_GAIN_P, 32'd3, 1'b0, '0, '0);
    add_row(ROW_CFG,   REG_GAIN_I, 32'd1, 1'b0, '0, '0);
    add_row(ROW_CFG,   REG_GAIN_D, 32'd0, 1'b0, '0, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'hffff, '0);
    add_row(ROW_ITEM,  REG_TARGET, '0, 1'b0, 16'd40000, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table
    prev_cfg = 1'b0;
    foreach (stim_plan[i]) begin
      if (stim_plan[i].kind == ROW_CFG) begin
        if (!prev_cfg) drain_results();
        set_register(stim_plan[i].regsel, stim_plan[i].value);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) close_bus();
        send_word(stim_plan[i].cmd, stim_plan[i].period,
                  stim_plan[i].kind == ROW_KNOWN, stim_plan[i].known);
        prev_cfg = 1'b0;
      end
    end

    // random control phases, each with a fresh register set
    phase = 0;
    while (items_sent < ITEM_TOTAL) begin
      drain_results();
      set_register(REG_TARGET, (32'($urandom) & 32'hffff_0000) | 32'(pick_target()));
      set_register(REG_GAIN_P, (32'($urandom) & 32'hffff_0000) | 32'(pick_gain()));
      set_register(REG_GAIN_I, (32'($urandom) & 32'hffff_0000) | 32'(pick_gain()));
      set_register(REG_GAIN_D, (32'($urandom) & 32'hffff_0000) | 32'(pick_gain()));
      set_register(REG_SCALE,  (32'($urandom) & 32'hfff0_0000) | 32'(pick_scale()));
      close_bus();
      if (phase == 2) hold_req = 1'b1;
      len = $urandom_range(30, 120);
      while (len > 0 && items_sent < ITEM_TOTAL) begin
        quiet = (items_sent >= ITEM_TOTAL - QUIET_TAIL);
        cmd   = ($urandom_range(0, 15) == 0);
        send_word(cmd, cmd ? 16'($urandom) : pick_period(), 1'b0, '0);
        len--;
      end
      phase++;
    end

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/msp_pkg.sv
rtl/msp_div.sv
rtl/msp_mac.sv
rtl/motor_speed_pid_regulator_core.sv
dv/tb_top.sv
